### sv/assert_macros.svh
// Assertion macros for the slot counter table back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### sv/cscct_pkg.sv
// Types, command codes and CRC helpers for the slot counter table.
`default_nettype none
package cscct_pkg;

   localparam logic [2:0] CMD_CLEAR  = 3'd0;
   localparam logic [2:0] CMD_SCAN   = 3'd1;
   localparam logic [2:0] CMD_UPDATE = 3'd2;
   localparam logic [2:0] CMD_SEED   = 3'd3;
   localparam logic [2:0] CMD_QUERY  = 3'd4;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
   localparam int unsigned CRC_BITS = 40;

   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  slot;
      logic [31:0] counter_value;
      logic [31:0] stored_crc;
   } req_type;

   typedef struct packed {
      logic [31:0] record_check;
      logic        accepted;
      logic [31:0] slot_counter;
   } rsp_type;

   // Classified command as it waits between the front and the back.
   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  slot;
      logic        in_range;
      logic        crc_ok;
      logic [31:0] value;
      logic [31:0] check;
   } work_type;

   // Bit-serial reflected CRC register update; used on constants only.
   function automatic logic [31:0] crc_bits(input logic [CRC_BITS-1:0] d,
                                            input logic [31:0] init);
      logic [31:0] c;
      c = init;
      for (int k = 0; k < CRC_BITS; k++) begin
         c[0] = c[0] ^ d[k];
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // Contribution of one message bit to the CRC register.
   function automatic logic [31:0] crc_col(input int unsigned i);
      logic [CRC_BITS-1:0] d;
      d = '0;
      d[i] = 1'b1;
      return crc_bits(d, 32'd0);
   endfunction

endpackage
`default_nettype wire

### sv/crc_checked_slot_counter_table_core.sv
// A result word passes through the queue entry, the current-command register and the result register.
// The back side handles one word at a time: it takes the next word only once the table read-then-write is done.
// The front side keeps taking words into a two-entry queue while the back side works.
// Reset clears the queue, the result valid flag and the per-slot valid bits at once,
// so every slot reads as zero right after reset; there is no clearing pass.
`default_nettype none
module crc_checked_slot_counter_table_core #(
   parameter int SLOT_COUNT = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire cscct_pkg::req_type req_word,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output cscct_pkg::rsp_type      rsp_word
);
   import cscct_pkg::*;

   work_type front_work, q_head;
   logic     q_full, q_empty, q_pop, q_push;

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   cscct_front #(.SLOT_COUNT(SLOT_COUNT)) u_front (
      .req_word (req_word),
      .work     (front_work)
   );

   cscct_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (front_work),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   cscct_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule
`default_nettype wire

### sv/cscct_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module cscct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### sv/cscct_front.sv
// Front end: record CRC and command classification of an incoming word.
`default_nettype none
module cscct_front #(
   parameter int SLOT_COUNT = 8
) (
   input  wire cscct_pkg::req_type  req_word,
   output cscct_pkg::work_type      work
);
   import cscct_pkg::*;

   logic [CRC_BITS-1:0] msg;
   logic [31:0]         term [CRC_BITS];
   logic [31:0]         acc;
   logic [31:0]         check;

   // Slot byte goes first, then the counter least significant byte first.
   assign msg = {req_word.counter_value, req_word.slot};

   // The CRC is linear, so each message bit flips a fixed set of bits.
   for (genvar i = 0; i < CRC_BITS; i++) begin : g_col
      localparam logic [31:0] COL = crc_col(i);
      assign term[i] = msg[i] ? COL : 32'd0;
   end

   always_comb begin
      acc = crc_bits('0, CRC_INIT);
      for (int i = 0; i < CRC_BITS; i++) begin
         acc = acc ^ term[i];
      end
   end

   assign check = ~acc;

   always_comb begin
      work.slot     = req_word.slot;
      work.value    = req_word.counter_value;
      work.check    = check;
      work.crc_ok   = (check == req_word.stored_crc);
      work.in_range = ({1'b0, req_word.slot} < 9'(SLOT_COUNT));
      unique case (req_word.cmd)
         CMD_CLEAR:  work.op = CMD_CLEAR;
         CMD_SCAN:   work.op = CMD_SCAN;
         CMD_UPDATE: work.op = CMD_UPDATE;
         CMD_SEED:   work.op = CMD_SEED;
         default:    work.op = CMD_QUERY;
      endcase
   end

endmodule
`default_nettype wire

### sv/cscct_queue.sv
// Short queue of classified commands between front and back.
`default_nettype none
module cscct_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire cscct_pkg::work_type push_data,
   output logic                     full,
   input  wire logic                pop,
   output logic                     empty,
   output cscct_pkg::work_type      head
);
   import cscct_pkg::*;

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   work_type        entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wptr_ff, wptr_in;
   logic [PW-1:0]   rptr_ff, rptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign full  = (count_ff == CW'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (pop) begin
         rptr_in = (rptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

### sv/cscct_back.sv
// Back end: table read, modify and write, and the result register.
`default_nettype none
`include "assert_macros.svh"
module cscct_back #(
   parameter int SLOT_COUNT = 8,
   localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cscct_pkg::work_type head,
   input  wire logic                q_empty,
   output logic                     q_pop,
   input  wire logic                rsp_stall,
   output logic                     rsp_valid,
   output cscct_pkg::rsp_type       rsp_word
);
   import cscct_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                  state_ff, state_in;
   work_type              cur_ff;
   logic [SLOT_COUNT-1:0] valid_ff, valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_word_ff, rsp_word_in;

   logic [AW-1:0] head_idx, cur_idx;
   logic [31:0]   rd_data, old_val, now_val;
   logic          exec_fire, wr_en, accepted;

   assign head_idx  = head.in_range ? head.slot[AW-1:0] : '0;
   assign cur_idx   = cur_ff.in_range ? cur_ff.slot[AW-1:0] : '0;
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;
   assign exec_fire = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);

   cscct_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cur_idx),
      .wr_data (cur_ff.value),
      .rd_en   (q_pop),
      .rd_addr (head_idx),
      .rd_data (rd_data)
   );

   // An entry not written since the last reset, clear or seed reads as zero.
   assign old_val = valid_ff[cur_idx] ? rd_data : 32'd0;

   always_comb begin
      valid_in = valid_ff;
      wr_en    = 1'b0;
      now_val  = old_val;
      accepted = cur_ff.in_range;
      unique case (cur_ff.op)
         CMD_CLEAR: begin
            now_val = 32'd0;
            if (exec_fire) begin
               valid_in = '0;
            end
         end
         CMD_SCAN: begin
            accepted = cur_ff.in_range && cur_ff.crc_ok;
            if (accepted && (cur_ff.value > old_val)) begin
               now_val = cur_ff.value;
               wr_en   = exec_fire;
               if (exec_fire) begin
                  valid_in[cur_idx] = 1'b1;
               end
            end
         end
         CMD_UPDATE: begin
            if (cur_ff.in_range) begin
               now_val = cur_ff.value;
               wr_en   = exec_fire;
               if (exec_fire) begin
                  valid_in[cur_idx] = 1'b1;
               end
            end
         end
         CMD_SEED: begin
            if (cur_ff.in_range) begin
               now_val = cur_ff.value;
               wr_en   = exec_fire;
               if (exec_fire) begin
                  valid_in          = '0;
                  valid_in[cur_idx] = 1'b1;
               end
            end
         end
         default: begin
            now_val = old_val;
         end
      endcase
   end

   always_comb begin
      rsp_word_in.record_check = cur_ff.check;
      rsp_word_in.accepted     = accepted;
      rsp_word_in.slot_counter = cur_ff.in_range ? now_val : 32'd0;
   end

   always_comb begin
      state_in = state_ff;
      if (q_pop) begin
         state_in = ST_EXEC;
      end else if (exec_fire) begin
         state_in = ST_IDLE;
      end
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (q_pop) begin
         cur_ff <= head;
      end
      if (exec_fire) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `ASSERT_NEXT(a_pop_to_exec, clock, reset, q_pop, state_ff == ST_EXEC)
   `ASSERT_NEXT(a_clear_empties, clock, reset, exec_fire && cur_ff.op == CMD_CLEAR, valid_ff == '0)
   `ASSERT_NEXT(a_seed_single, clock, reset, exec_fire && cur_ff.op == CMD_SEED && cur_ff.in_range, $onehot(valid_ff))
   `ASSERT_IMPLIES(a_rsp_from_exec, clock, reset, $rose(rsp_valid_ff), $past(exec_fire))

endmodule
`default_nettype wire

### dv/tb_crc_checked_slot_counter_table_core.sv
// Self-checking testbench for the CRC-checked slot counter table core.
`default_nettype none
module tb_crc_checked_slot_counter_table_core;
   timeunit 1ns;
   timeprecision 1ps;

   import cscct_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int SLOTS = 8;
   localparam int RANDOM_WORDS = 1700;
   localparam int CALM_TAIL = 150;
   localparam int HOLD_START = 400;
   localparam int HOLD_CYCLES = 60;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int REPORT_LIMIT = 10;
   localparam logic [31:0] REFLECTED_POLY = 32'hEDB8_8320;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall;
   logic rsp_pause = 1'b0;
   logic hold_off = 1'b0;
   rsp_type rsp_word;

   req_type cmd_backlog[$];
   rsp_type pending_results[$];
   logic [31:0] slot_table[SLOTS];

   int words_sent = 0;
   int calm_from = 0;
   int gap_left = 0;
   int stall_left = 0;
   int quiet_cycles = 0;
   int mismatches = 0;

   crc_checked_slot_counter_table_core #(.SLOT_COUNT(SLOTS)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word)
   );

   assign rsp_stall = rsp_pause | hold_off;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // The record is the slot byte followed by the counter, least significant byte first,
   // so bit k of {counter, slot} is the k-th bit shifted into the reflected register.
   function automatic logic [31:0] golden_crc(logic [7:0] slot, logic [31:0] value);
      logic [39:0] msg;
      logic [31:0] r;
      msg = {value, slot};
      r = '1;
      for (int k = 0; k < 40; k++) begin
         if (r[0] ^ msg[k]) begin
            r = (r >> 1) ^ REFLECTED_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return ~r;
   endfunction

   function automatic rsp_type apply_command(req_type w);
      rsp_type r;
      logic in_range;
      r.record_check = golden_crc(w.slot, w.counter_value);
      in_range = w.slot < SLOTS;
      r.accepted = in_range;
      case (w.cmd)
         CMD_CLEAR: begin
            foreach (slot_table[i]) slot_table[i] = '0;
         end
         CMD_SCAN: begin
            r.accepted = in_range && (r.record_check == w.stored_crc);
            if (r.accepted && w.counter_value > slot_table[w.slot]) begin
               slot_table[w.slot] = w.counter_value;
            end
         end
         CMD_UPDATE: begin
            if (in_range) slot_table[w.slot] = w.counter_value;
         end
         CMD_SEED: begin
            if (in_range) begin
               foreach (slot_table[i]) slot_table[i] = '0;
               slot_table[w.slot] = w.counter_value;
            end
         end
         default: ;
      endcase
      r.slot_counter = in_range ? slot_table[w.slot] : '0;
      return r;
   endfunction

   task automatic add_word(logic [2:0] cmd, logic [7:0] slot, logic [31:0] value,
                           logic [31:0] crc);
      req_type w;
      w.cmd = cmd;
      w.slot = slot;
      w.counter_value = value;
      w.stored_crc = crc;
      cmd_backlog.push_back(w);
   endtask

   task automatic note_mismatch(string what, rsp_type want, rsp_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("%0t: %s: expected check %h accepted %b counter %h, got %h %b %h",
                  $realtime, what, want.record_check, want.accepted, want.slot_counter,
                  got.record_check, got.accepted, got.slot_counter);
      end
   endtask

   task automatic check_result(rsp_type got);
      rsp_type want;
      if (pending_results.size() == 0) begin
         note_mismatch("result word with nothing outstanding", '0, got);
         return;
      end
      want = pending_results.pop_front();
      if (got.record_check !== want.record_check || got.accepted !== want.accepted ||
          got.slot_counter !== want.slot_counter) begin
         note_mismatch("result word differs", want, got);
      end
   endtask

   task automatic add_directed();
      logic [2:0] spare;
      add_word(CMD_QUERY, 8'd0, 32'd0, 32'd0);
      add_word(CMD_UPDATE, 8'd0, 32'hFFFF_FFFF, 32'd0);
      add_word(CMD_UPDATE, 8'd7, 32'd1, 32'hFFFF_FFFF);
      add_word(CMD_SCAN, 8'd7, 32'd5, golden_crc(8'd7, 32'd5));
      // A lower counter is accepted but the stored one stays.
      add_word(CMD_SCAN, 8'd7, 32'd2, golden_crc(8'd7, 32'd2));
      add_word(CMD_SCAN, 8'd7, 32'd9, golden_crc(8'd7, 32'd9) ^ 32'h1);
      add_word(CMD_SCAN, 8'd8, 32'd9, golden_crc(8'd8, 32'd9));
      add_word(CMD_UPDATE, 8'd255, 32'h1234_5678, 32'd0);
      add_word(CMD_SEED, 8'd255, 32'h0000_0042, 32'd0);
      add_word(CMD_QUERY, 8'd0, 32'd0, 32'd0);
      add_word(CMD_SEED, 8'd3, 32'd1234, 32'd0);
      add_word(CMD_QUERY, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_word(CMD_CLEAR, 8'd200, 32'd0, 32'd0);
      add_word(CMD_QUERY, 8'd3, 32'd0, 32'd0);
      add_word(CMD_UPDATE, 8'd1, 32'd0, 32'd0);
      add_word(CMD_SCAN, 8'd1, 32'd0, golden_crc(8'd1, 32'd0));
      add_word(CMD_UPDATE, 8'd3, 32'd77, 32'd0);
      spare = CMD_QUERY;
      repeat (3) begin
         spare++;
         add_word(spare, 8'd3, 32'hAAAA_5555, 32'h5555_AAAA);
      end
      add_word(CMD_CLEAR, 8'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_word(CMD_SCAN, 8'd0, 32'hFFFF_FFFF, golden_crc(8'd0, 32'hFFFF_FFFF));
      add_word(CMD_UPDATE, 8'd6, 32'h8000_0000, 32'd0);
      add_word(CMD_SCAN, 8'd6, 32'h7FFF_FFFF, golden_crc(8'd6, 32'h7FFF_FFFF));
   endtask

   task automatic add_random();
      logic [2:0] cmd;
      logic [7:0] slot;
      logic [31:0] value;
      logic [31:0] crc;
      int pick;
      repeat (RANDOM_WORDS) begin
         pick = $urandom_range(0, 99);
         slot = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, SLOTS - 1))
                                             : 8'($urandom_range(0, 255));
         value = ($urandom_range(0, 99) < 40) ? 32'($urandom_range(0, 15)) : $urandom;
         crc = $urandom;
         if (pick < 42) begin
            cmd = CMD_SCAN;
            // Most records carry a good CRC so they reach the table.
            if ($urandom_range(0, 99) < 80) begin
               crc = golden_crc(slot, value);
            end else if ($urandom_range(0, 1) == 1) begin
               crc = golden_crc(slot, value) ^ (32'h1 << $urandom_range(0, 31));
            end
         end else if (pick < 64) begin
            cmd = CMD_UPDATE;
         end else if (pick < 80) begin
            cmd = CMD_QUERY;
         end else if (pick < 87) begin
            cmd = CMD_SEED;
         end else if (pick < 91) begin
            cmd = CMD_CLEAR;
         end else begin
            cmd = 3'($urandom_range(0, 7));
            slot = 8'($urandom_range(0, 255));
            value = $urandom;
         end
         add_word(cmd, slot, value, crc);
      end
   endtask

   initial begin
      foreach (slot_table[i]) slot_table[i] = '0;
      add_directed();
      add_random();
      calm_from = cmd_backlog.size() - CALM_TAIL;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (cmd_backlog.size() != 0 || req_valid || pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Sender: a new word is offered only once the current one is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_results.push_back(apply_command(req_word));
            words_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left == 0 && words_sent < calm_from && $urandom_range(0, 7) == 0) begin
               gap_left = $urandom_range(1, 3);
            end
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
               req_word <= cmd_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks every taken result word and stalls in short random bursts.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pause <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result(rsp_word);
         if (stall_left > 0) begin
            stall_left--;
            rsp_pause <= 1'b1;
         end else if (words_sent < calm_from && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 3) - 1;
            rsp_pause <= 1'b1;
         end else begin
            rsp_pause <= 1'b0;
         end
      end
   end

   // One long hold-off lets the internal queue fill so the input side backs up.
   initial begin
      while (words_sent < HOLD_START) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (cmd_backlog.size() == 0 && !req_valid && pending_results.size() == 0)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

endmodule
`default_nettype wire

### files.f
+incdir+sv
sv/cscct_pkg.sv
sv/cscct_ram.sv
sv/cscct_front.sv
sv/cscct_queue.sv
sv/cscct_back.sv
sv/crc_checked_slot_counter_table_core.sv
dv/tb_crc_checked_slot_counter_table_core.sv
